// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

    localparam int NUM_COLUMNS_DEF = 80;
    localparam int NUM_ROWS_DEF    = 25;

    localparam int MODE_W     = 2;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int CIDX_OUT_W = 11;
    localparam int COLOR_W    = 4;
    localparam int ATTR_W     = 2 * COLOR_W;
    localparam int CELL_W     = ATTR_W + CHAR_W;
    localparam int CFG_IDX_W  = 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FG = 1'b0,
        CFG_BG = 1'b1
    } cfg_idx_t;

    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0]  CHAR_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0]  CHAR_NUL     = 8'd0;
    localparam logic [COLOR_W-1:0] FG_RESET     = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET     = 4'd1;
    localparam logic [ATTR_W-1:0]  ATTR_RESET   = {BG_RESET, FG_RESET};

    typedef struct packed {
        logic [ROW_OUT_W-1:0]  cursor_row;
        logic [COL_OUT_W-1:0]  cursor_col;
        logic [CIDX_OUT_W-1:0] cursor_index;
        logic                  scrolled;
        logic [CHAR_W-1:0]     cell_char;
        logic [ATTR_W-1:0]     cell_attr;
    } tcw_res_t;

    typedef struct packed {
        logic     load;
        tcw_res_t data;
    } tcw_load_t;

endpackage

// ----- rtl/core/tcw_channels.sv -----
interface tcw_cmd_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, mode, char_code, cell_index, input ready);
    modport sink   (input valid, mode, char_code, cell_index, output ready);
endinterface

interface tcw_res_if;
    import tcw_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [ROW_OUT_W-1:0]  cursor_row;
    logic [COL_OUT_W-1:0]  cursor_col;
    logic [CIDX_OUT_W-1:0] cursor_index;
    logic                  scrolled;
    logic [CHAR_W-1:0]     cell_char;
    logic [ATTR_W-1:0]     cell_attr;

    modport source (output valid, cursor_row, cursor_col, cursor_index, scrolled,
                    cell_char, cell_attr, input ready);
    modport sink   (input valid, cursor_row, cursor_col, cursor_index, scrolled,
                    cell_char, cell_attr, output ready);
endinterface

// ----- rtl/core/tcw_screen_ram.sv -----
module tcw_screen_ram #(
    parameter int DEPTH  = tcw_pkg::NUM_COLUMNS_DEF * tcw_pkg::NUM_ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]  rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
module tcw_ctrl #(
    parameter int   NUM_COLUMNS = tcw_pkg::NUM_COLUMNS_DEF,
    parameter int   NUM_ROWS    = tcw_pkg::NUM_ROWS_DEF,
    localparam int  ADDR_W      = $clog2(NUM_COLUMNS * NUM_ROWS)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tcw_cmd_if.sink                     cmd,
    input  logic                        out_free,
    input  logic [tcw_pkg::ATTR_W-1:0]  attr,
    output tcw_pkg::tcw_load_t          res_load,
    output logic                        wr_en,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [tcw_pkg::CELL_W-1:0]  wr_data,
    output logic                        rd_en,
    output logic [ADDR_W-1:0]           rd_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  rd_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = NUM_COLUMNS * NUM_ROWS;
    localparam int COPY_COUNT = CELL_COUNT - NUM_COLUMNS;
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int COL_W      = $clog2(NUM_COLUMNS);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_SWEEP = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              drain_reg, drain_next;
    logic              scroll_reg, scroll_next;
    logic              report_reg, report_next;
    logic [ATTR_W-1:0] sweep_attr_reg, sweep_attr_next;
    logic              stage_v_reg, stage_v_next;
    logic [ADDR_W-1:0] stage_addr_reg, stage_addr_next;
    logic              stage_copy_reg, stage_copy_next;
    logic              rd_ok_reg, rd_ok_next;

    logic              accept;
    logic              is_newline, is_return, is_print;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              wrap, row_over;
    logic              put_we;
    logic [ADDR_W-1:0] cur_addr;
    logic [ADDR_W-1:0] sweep_rd_addr;
    logic              sweep_copy;
    logic [31:0]       idx32;
    logic              idx_ok;
    logic [ADDR_W-1:0] idx_addr;
    logic              load_now;
    logic              res_scrolled;
    logic [CHAR_W-1:0] res_char;
    logic [ATTR_W-1:0] res_attr;
    logic [ADDR_W-1:0] cidx_next;
    logic [31:0]       row32, col32, cidx32;

    assign accept     = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE) && out_free;
    assign is_newline = (cmd.char_code == CHAR_NEWLINE);
    assign is_return  = (cmd.char_code == CHAR_RETURN);
    assign is_print   = !is_newline && !is_return;
    assign col_inc    = {1'b0, col_reg} + (COL_W+1)'(1);
    assign row_inc    = {1'b0, row_reg} + (ROW_W+1)'(1);
    assign wrap       = (col_inc >= (COL_W+1)'(NUM_COLUMNS));
    assign row_over   = (row_inc >= (ROW_W+1)'(NUM_ROWS));
    assign cur_addr   = base_reg + ADDR_W'(col_reg);
    assign put_we     = accept && (cmd.mode == MODE_PUT) && is_print;

    assign idx32      = 32'(cmd.cell_index);
    assign idx_ok     = (idx32 < 32'(CELL_COUNT));
    assign idx_addr   = idx32[ADDR_W-1:0];

    assign sweep_copy    = scroll_reg && (cnt_reg < ADDR_W'(COPY_COUNT));
    assign sweep_rd_addr = cnt_reg + ADDR_W'(NUM_COLUMNS);

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        base_next       = base_reg;
        cnt_next        = cnt_reg;
        drain_next      = drain_reg;
        scroll_next     = scroll_reg;
        report_next     = report_reg;
        sweep_attr_next = sweep_attr_reg;
        stage_v_next    = 1'b0;
        stage_addr_next = stage_addr_reg;
        stage_copy_next = stage_copy_reg;
        rd_ok_next      = rd_ok_reg;
        rd_en           = 1'b0;
        rd_addr         = sweep_rd_addr;
        load_now        = 1'b0;
        res_scrolled    = 1'b0;
        res_char        = CHAR_NUL;
        res_attr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd.mode == MODE_PUT)
                    begin
                        if (is_newline || (is_print && wrap))
                        begin
                            col_next = '0;
                            if (row_over)
                            begin
                                // bottom row stays; shift the screen up
                                state_next      = S_SWEEP;
                                cnt_next        = '0;
                                drain_next      = 1'b0;
                                scroll_next     = 1'b1;
                                report_next     = 1'b1;
                                sweep_attr_next = attr;
                            end
                            else
                            begin
                                row_next  = row_inc[ROW_W-1:0];
                                base_next = base_reg + ADDR_W'(NUM_COLUMNS);
                                load_now  = 1'b1;
                            end
                        end
                        else if (is_return)
                        begin
                            col_next = '0;
                            load_now = 1'b1;
                        end
                        else
                        begin
                            col_next = col_inc[COL_W-1:0];
                            load_now = 1'b1;
                        end
                    end
                    else if (cmd.mode == MODE_CLEAR)
                    begin
                        row_next        = '0;
                        col_next        = '0;
                        base_next       = '0;
                        state_next      = S_SWEEP;
                        cnt_next        = '0;
                        drain_next      = 1'b0;
                        scroll_next     = 1'b0;
                        report_next     = 1'b1;
                        sweep_attr_next = attr;
                    end
                    else if (cmd.mode == MODE_READ)
                    begin
                        rd_en      = idx_ok;
                        rd_addr    = idx_addr;
                        rd_ok_next = idx_ok;
                        state_next = S_READ;
                    end
                    else
                    begin
                        load_now = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                load_now = 1'b1;
                if (rd_ok_reg)
                begin
                    res_char = rd_data[CHAR_W-1:0];
                    res_attr = rd_data[CELL_W-1:CHAR_W];
                end
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                if (!drain_reg)
                begin
                    // read the cell one row below (or blank this one), write it back next cycle
                    stage_v_next    = 1'b1;
                    stage_addr_next = cnt_reg;
                    stage_copy_next = sweep_copy;
                    rd_en           = sweep_copy;
                    if (cnt_reg == ADDR_W'(CELL_COUNT - 1))
                    begin
                        drain_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + ADDR_W'(1);
                    end
                end
                else
                begin
                    state_next   = S_IDLE;
                    load_now     = report_reg;
                    res_scrolled = scroll_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign cidx_next = base_next + ADDR_W'(col_next);
    assign row32     = 32'(row_next);
    assign col32     = 32'(col_next);
    assign cidx32    = 32'(cidx_next);

    assign res_load.load              = load_now;
    assign res_load.data.cursor_row   = row32[ROW_OUT_W-1:0];
    assign res_load.data.cursor_col   = col32[COL_OUT_W-1:0];
    assign res_load.data.cursor_index = cidx32[CIDX_OUT_W-1:0];
    assign res_load.data.scrolled     = res_scrolled;
    assign res_load.data.cell_char    = res_char;
    assign res_load.data.cell_attr    = res_attr;

    assign wr_en   = stage_v_reg || put_we;
    assign wr_addr = put_we ? cur_addr : stage_addr_reg;
    assign wr_data = put_we ? {attr, cmd.char_code}
                   : (stage_copy_reg ? rd_data : {sweep_attr_reg, CHAR_NUL});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset runs a full blanking sweep with the reset attribute
            state_reg      <= S_SWEEP;
            row_reg        <= '0;
            col_reg        <= '0;
            base_reg       <= '0;
            cnt_reg        <= '0;
            drain_reg      <= 1'b0;
            scroll_reg     <= 1'b0;
            report_reg     <= 1'b0;
            sweep_attr_reg <= ATTR_RESET;
            stage_v_reg    <= 1'b0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            base_reg       <= base_next;
            cnt_reg        <= cnt_next;
            drain_reg      <= drain_next;
            scroll_reg     <= scroll_next;
            report_reg     <= report_next;
            sweep_attr_reg <= sweep_attr_next;
            stage_v_reg    <= stage_v_next;
            rd_ok_reg      <= rd_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_addr_reg <= stage_addr_next;
        stage_copy_reg <= stage_copy_next;
    end

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(stage_v_reg && put_we))
        else $error("sweep write collides with character write");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, row_reg} < (ROW_W+1)'(NUM_ROWS)) && ({1'b0, col_reg} < (COL_W+1)'(NUM_COLUMNS)))
        else $error("cursor outside the screen");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_IDLE))
        else $error("read result not delivered after one cycle");

    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_v_reg |-> (32'(stage_addr_reg) < 32'(CELL_COUNT)))
        else $error("sweep write address beyond the last cell");

    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ready |-> !stage_v_reg)
        else $error("item taken while a sweep write is pending");

endmodule

// ----- rtl/core/text_console_writer_top.sv -----
// Put character without scroll: result is registered at the accept edge.
// Read: the synchronous screen memory read is taken in S_READ, then the result is registered.
// Clear and scroll: a sweep through the memory port over all NUM_COLUMNS*NUM_ROWS cells
// (one cell copied or blanked per cycle), then the result.
// Reset: cursor homes, colors go to 7/1, and a blanking sweep over all cells
// runs with ready low; configuration writes are taken during it.
module text_console_writer_top #(
    parameter int NUM_COLUMNS = tcw_pkg::NUM_COLUMNS_DEF,
    parameter int NUM_ROWS    = tcw_pkg::NUM_ROWS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tcw_cmd_if.sink                       cmd,
    tcw_res_if.source                     res,
    input  logic                          cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]   cfg_wdata
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = NUM_COLUMNS * NUM_ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic               out_valid_reg;
    tcw_res_t           out_data_reg;
    logic               out_free;
    tcw_load_t          res_load;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FG:  fg_reg <= cfg_wdata;
                CFG_BG:  bg_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load.load)
        begin
            out_data_reg <= res_load.data;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.cursor_row   = out_data_reg.cursor_row;
    assign res.cursor_col   = out_data_reg.cursor_col;
    assign res.cursor_index = out_data_reg.cursor_index;
    assign res.scrolled     = out_data_reg.scrolled;
    assign res.cell_char    = out_data_reg.cell_char;
    assign res.cell_attr    = out_data_reg.cell_attr;

    tcw_ctrl #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .out_free (out_free),
        .attr     ({bg_reg, fg_reg}),
        .res_load (res_load),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    tcw_screen_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
